@@ rtl/wgm_pkg.sv @@
// Package for the wildcard glob matcher: item widths, command codes,
// wildcard byte values and the structs passed between top level and engine.
// No dependencies.
`default_nettype none

package wgm_pkg;

  // Default capacity of the pattern store in bytes.
  localparam int PATTERN_LEN_DEF = 32;

  // Field widths of one input item.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;

  // Command codes carried on the input tuser.
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUBJECT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd3;

  // Wildcard bytes in a pattern.
  localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'd42;
  localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'd63;

  // One input item as held in the input register.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] char_byte;
  } wgm_item_t;

  // An item handed to the engine, with the strobe that commits it.
  typedef struct packed {
    logic      fire;
    wgm_item_t item;
  } wgm_op_t;

  // Match verdict, valid whenever an end-of-subject item is committed.
  typedef struct packed {
    logic matched;
    logic too_long;
  } wgm_res_t;

endpackage

`default_nettype wire

@@ rtl/wildcard_glob_matcher_top.sv @@
// Path: an end-of-subject item accepted into the input register passes
// through the combinational engine into the result register, which drives
// out_tvalid.
// Throughput: one item per cycle, every command, set by the update of the
// live-position vector (one add across PATTERN_LEN+1 bits); an end item waits
// in the input register while an earlier result is held.
// Reset: pattern count, overflow flag and handshake state clear, only the
// start position is live; pattern store contents are left as they are.
// Top level of the wildcard glob matcher; depends on wgm_pkg and wgm_engine.
`default_nettype none

module wildcard_glob_matcher_top #(
  parameter int PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] char_byte
  input  wire logic [wgm_pkg::CMD_W-1:0]  in_tuser,   // [1:0] command
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata   // [0] matched, [1] too_long, rest 0
);
  import wgm_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  wgm_item_t s1_item_r;
  logic      in_fire;
  logic      s1_is_end;
  logic      out_free;
  logic      s1_fire;
  wgm_op_t   eng_op;
  wgm_res_t  eng_res;
  logic      out_valid_r, out_valid_nxt;
  wgm_res_t  out_res_r;

  // Stage handshake: the input register drains unless it holds an end item
  // and the result register is still occupied.
  assign s1_is_end = s1_item_r.command == CMD_END;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_is_end || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_fire && s1_is_end) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.command   <= in_tuser;
      s1_item_r.char_byte <= in_tdata;
    end
  end

  assign eng_op.fire = s1_fire;
  assign eng_op.item = s1_item_r;

  wgm_engine #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (eng_op),
    .res   (eng_res)
  );

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_end) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.too_long, out_res_r.matched};

  // An overflowed pattern never reports a match.
  a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("match reported with overflowed pattern");

  // A committed end item always leaves a result behind.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_is_end) |=> out_tvalid)
    else $error("end item committed without a result");

  // A held result is never overwritten by a later end item.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !(s1_fire && s1_is_end))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/wgm_engine.sv @@
// Matching engine: pattern store, pattern count, overflow flag and the
// vector of live pattern positions, updated once per committed item.
// Depends on wgm_pkg.
`default_nettype none

module wgm_engine #(
  parameter int PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wgm_pkg::wgm_op_t op,
  output wgm_pkg::wgm_res_t     res
);
  import wgm_pkg::*;

  localparam int CNT_W = $clog2(PATTERN_LEN + 1);
  localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam logic [PATTERN_LEN:0] LIVE_START = (PATTERN_LEN + 1)'(1);

  logic [BYTE_W-1:0]      store_r [PATTERN_LEN];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [PATTERN_LEN:0]   live_r, live_nxt;
  logic                   store_we;

  logic [PATTERN_LEN-1:0] used;
  logic [PATTERN_LEN-1:0] star;
  logic [PATTERN_LEN-1:0] stay;
  logic [PATTERN_LEN-1:0] step;
  logic [PATTERN_LEN:0]   star_ext;
  logic [PATTERN_LEN:0]   carry_sum;
  logic [PATTERN_LEN:0]   closed;
  logic [PATTERN_LEN:0]   advanced;
  logic                   has_room;

  // Per-position decode of the stored pattern; only bytes below the count
  // take part.
  always_comb begin
    for (int i = 0; i < PATTERN_LEN; i++) begin
      used[i] = count_r > CNT_W'(i);
      star[i] = used[i] && (store_r[i] == STAR_BYTE);
    end
  end

  // Closure over runs of stars. A live bit inside a run of star positions
  // must spread to every later position of the run and to the one after
  // it; the carry chain of an add does exactly that.
  assign star_ext  = {1'b0, star};
  assign carry_sum = (live_r & star_ext) + star_ext;
  assign closed    = live_r | (carry_sum ^ star_ext);

  // One subject byte: a star keeps its position live, a literal or '?'
  // that matches moves the position one step on.
  always_comb begin
    for (int i = 0; i < PATTERN_LEN; i++) begin
      stay[i] = closed[i] && star[i];
      step[i] = closed[i] && used[i] && !star[i] &&
                ((store_r[i] == QMARK_BYTE) || (store_r[i] == op.item.char_byte));
    end
  end

  assign advanced = {step, 1'b0} | {1'b0, stay};
  assign has_room = count_r < CNT_W'(PATTERN_LEN);

  // Verdict for an end-of-subject item.
  assign res.matched  = closed[count_r] && !ovf_r;
  assign res.too_long = ovf_r;

  // Next-state decode per command.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    live_nxt  = live_r;
    store_we  = 1'b0;
    if (op.fire) begin
      case (op.item.command)
        CMD_CLEAR: begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          live_nxt  = LIVE_START;
        end
        CMD_APPEND: begin
          if (has_room) begin
            store_we  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          live_nxt = LIVE_START;
        end
        CMD_SUBJECT: begin
          live_nxt = advanced;
        end
        default: begin
          live_nxt = LIVE_START;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      live_r  <= LIVE_START;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      live_r  <= live_nxt;
    end
  end

  // Pattern store; entries at or above the count are never looked at.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[IDX_W-1:0]] <= op.item.char_byte;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the wildcard glob matcher: a directed table, then
// random pattern and subject sequences, checked against an in-bench predictor.
// Depends on wgm_pkg and wildcard_glob_matcher_top.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  localparam int PAT_CAP       = PATTERN_LEN_DEF;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 470;

  localparam wgm_res_t V_HIT  = '{matched: 1'b1, too_long: 1'b0};
  localparam wgm_res_t V_MISS = '{matched: 1'b0, too_long: 1'b0};
  localparam wgm_res_t V_OVER = '{matched: 1'b0, too_long: 1'b1};
  localparam wgm_res_t V_NONE = '{matched: 1'b0, too_long: 1'b0};

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;

  wildcard_glob_matcher_top #(
    .PATTERN_LEN(PAT_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] char_byte
    .in_tuser  (in_tuser),    // [1:0] command
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)    // [0] matched, [1] too_long, rest 0
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: stored pattern, live positions and overflow flag.
  logic [7:0]       pat_bytes [PAT_CAP];
  int unsigned      pat_len      = 0;
  logic [PAT_CAP:0] live         = 1;
  logic             pat_overflow = 1'b0;

  // Verdicts still owed by the block, oldest first.
  wgm_res_t verdict_q [$];

  int unsigned items_sent  = 0;
  int unsigned mismatches  = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          idle_phase  = 0;

  // A live position that holds a star also makes the following position live.
  function automatic void close_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && pat_bytes[i] == STAR_BYTE) live[i+1] = 1'b1;
    end
  endfunction

  // Applies one item to the predictor; returns 1 when it yields a verdict.
  function automatic bit glob_step(input logic [1:0] cmd, input logic [7:0] chr,
                                   output wgm_res_t verdict);
    logic [PAT_CAP:0] next_live;
    verdict = V_NONE;
    case (cmd)
      CMD_CLEAR: begin
        pat_len      = 0;
        pat_overflow = 1'b0;
        live         = 1;
        return 1'b0;
      end
      CMD_APPEND: begin
        if (pat_len < PAT_CAP) begin
          pat_bytes[pat_len] = chr;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
        live = 1;
        return 1'b0;
      end
      CMD_SUBJECT: begin
        next_live = '0;
        close_stars();
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (pat_bytes[i] == STAR_BYTE) next_live[i] = 1'b1;
            else if (pat_bytes[i] == QMARK_BYTE || pat_bytes[i] == chr) next_live[i+1] = 1'b1;
          end
        end
        live = next_live;
        return 1'b0;
      end
      default: begin
        close_stars();
        verdict.matched  = live[pat_len] && !pat_overflow;
        verdict.too_long = pat_overflow;
        live = 1;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit log_mismatch();
    mismatches++;
    return mismatches <= 10;
  endfunction

  // Offers one item, waits for its acceptance and records what it should yield.
  // A typed verdict, where given, replaces the predicted one.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] chr,
                           input bit typed, input wgm_res_t typed_verdict);
    wgm_res_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= chr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (glob_step(cmd, chr, predicted)) verdict_q.push_back(typed ? typed_verdict : predicted);
    items_sent++;
  endtask

  // Stops offering until every owed verdict has come back.
  task automatic drain_verdicts();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pattern_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return STAR_BYTE;
    if (pick < 50) return QMARK_BYTE;
    if (pick < 88) return letter();
    return 8'($urandom_range(0, 255));
  endfunction

  // Random traffic: mostly a clear, a pattern and a few subjects, some of them
  // built to match; the rest is loose items and subjects left without an end.
  task automatic run_random(input int unsigned quota);
    logic [7:0]  pat [$];
    logic [7:0]  subj [$];
    int unsigned stop_at;
    int          pick;
    int          plen;
    int          idx;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, V_NONE);
        continue;
      end
      // Pattern lengths are mostly short; a few fill or overflow the store.
      pick = $urandom_range(0, 99);
      if (pick < 75)      plen = $urandom_range(0, 8);
      else if (pick < 93) plen = $urandom_range(9, PAT_CAP);
      else                plen = $urandom_range(PAT_CAP + 1, PAT_CAP + 4);
      pat.delete();
      repeat (plen) pat.push_back(pattern_char());
      send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, V_NONE);
      foreach (pat[k]) send_item(CMD_APPEND, pat[k], 1'b0, V_NONE);
      repeat ($urandom_range(1, 4)) begin
        subj.delete();
        if ($urandom_range(0, 99) < 60) begin
          foreach (pat[k]) begin
            if (pat[k] == STAR_BYTE) repeat ($urandom_range(0, 3)) subj.push_back(letter());
            else if (pat[k] == QMARK_BYTE) subj.push_back(8'($urandom_range(0, 255)));
            else subj.push_back(pat[k]);
          end
        end else begin
          repeat ($urandom_range(0, 10)) subj.push_back(letter());
        end
        // Occasionally spoil one byte of the subject.
        if (subj.size() != 0 && $urandom_range(0, 99) < 20) begin
          idx = $urandom_range(0, subj.size() - 1);
          subj[idx] = subj[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        foreach (subj[k]) send_item(CMD_SUBJECT, subj[k], 1'b0, V_NONE);
        if ($urandom_range(0, 99) < 92)
          send_item(CMD_END, 8'($urandom_range(0, 255)), 1'b0, V_NONE);
      end
    end
  endtask

  task automatic set_idle(input int phase, input int tx_pct, input int rx_pct);
    idle_phase  = phase;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Directed table; the verdict column is used only where typed is set.
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] chr;
    int         reps;
    bit         typed;
    wgm_res_t   verdict;
  } dir_row_t;

  localparam int DIR_N = 28;
  dir_row_t dir_rows [DIR_N] = '{
    '{CMD_END,     8'h00,      1,       1'b1, V_HIT},   // empty pattern, empty subject
    '{CMD_SUBJECT, 8'hFF,      1,       1'b0, V_NONE},
    '{CMD_END,     8'hFF,      1,       1'b1, V_MISS},  // empty pattern, one byte
    '{CMD_APPEND,  STAR_BYTE,  1,       1'b0, V_NONE},
    '{CMD_SUBJECT, 8'h00,      1,       1'b0, V_NONE},
    '{CMD_END,     8'h00,      1,       1'b0, V_NONE},
    '{CMD_CLEAR,   8'hFF,      1,       1'b0, V_NONE},
    '{CMD_APPEND,  8'h00,      1,       1'b0, V_NONE},  // zero byte is a plain literal
    '{CMD_APPEND,  QMARK_BYTE, 1,       1'b0, V_NONE},
    '{CMD_APPEND,  8'hFF,      1,       1'b0, V_NONE},
    '{CMD_SUBJECT, 8'h00,      1,       1'b0, V_NONE},
    '{CMD_SUBJECT, 8'h55,      1,       1'b0, V_NONE},
    '{CMD_APPEND,  STAR_BYTE,  1,       1'b0, V_NONE},  // append restarts the subject
    '{CMD_SUBJECT, 8'h00,      1,       1'b0, V_NONE},
    '{CMD_SUBJECT, STAR_BYTE,  1,       1'b0, V_NONE},  // a star in the subject is literal
    '{CMD_SUBJECT, 8'hFF,      1,       1'b0, V_NONE},
    '{CMD_SUBJECT, 8'h11,      1,       1'b0, V_NONE},
    '{CMD_END,     8'h00,      1,       1'b0, V_NONE},
    '{CMD_SUBJECT, 8'h61,      1,       1'b0, V_NONE},
    '{CMD_CLEAR,   8'h00,      1,       1'b0, V_NONE},  // clear in the middle of a subject
    '{CMD_END,     8'h00,      1,       1'b1, V_HIT},
    '{CMD_APPEND,  STAR_BYTE,  PAT_CAP, 1'b0, V_NONE},  // store filled exactly
    '{CMD_END,     8'hFF,      1,       1'b0, V_NONE},
    '{CMD_APPEND,  8'h61,      1,       1'b0, V_NONE},  // one byte past capacity
    '{CMD_SUBJECT, 8'h61,      1,       1'b0, V_NONE},
    '{CMD_END,     8'h00,      1,       1'b1, V_OVER},
    '{CMD_CLEAR,   8'h00,      1,       1'b0, V_NONE},  // clear drops the overflow
    '{CMD_END,     8'h00,      1,       1'b1, V_HIT}
  };

  // Result side: check each accepted verdict, stall at random, and hold off
  // once for a long stretch so that the block backs up into its input.
  initial begin
    wgm_res_t seen;
    wgm_res_t want;
    int       hold_left;
    bit       hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        seen.matched  = out_tdata[0];
        seen.too_long = out_tdata[1];
        if (verdict_q.size() == 0) begin
          if (log_mismatch())
            $display("[%0t] result with nothing owed: matched %0b too_long %0b",
                     $realtime, seen.matched, seen.too_long);
        end else begin
          want = verdict_q.pop_front();
          if (seen.matched != want.matched && log_mismatch())
            $display("[%0t] matched: expected %0b, got %0b",
                     $realtime, want.matched, seen.matched);
          if (seen.too_long != want.too_long && log_mismatch())
            $display("[%0t] too_long: expected %0b, got %0b",
                     $realtime, want.too_long, seen.too_long);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet == STALL_LIMIT) begin
        $display("wildcard_glob_matcher_top test failed");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then three random phases with different
  // idling on each side.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= CMD_CLEAR;
    set_idle(0, 18, 80);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps)
        send_item(dir_rows[r].cmd, dir_rows[r].chr, dir_rows[r].typed, dir_rows[r].verdict);
    end

    run_random(PHASE_ITEMS);
    drain_verdicts();
    set_idle(1, 80, 18);
    run_random(PHASE_ITEMS);
    set_idle(2, 0, 0);
    run_random(PHASE_ITEMS);

    drain_verdicts();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("wildcard_glob_matcher_top test passed");
    end else begin
      $display("wildcard_glob_matcher_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
